@@ hdl/cda_pkg.sv @@
package cda_pkg;

	// register indexes on the configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 20;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE = 1'b0,
		REG_PRECISION = 1'b1
	} cfg_reg_t;

	// result codes
	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_PERM  = 2'd1,
		ERR_INVAL = 2'd2
	} err_code_t;

	// mode bits
	localparam int MB_OFFSET  = 0;
	localparam int MB_FREQ    = 1;
	localparam int MB_MAXERR  = 2;
	localparam int MB_ESTERR  = 3;
	localparam int MB_STATUS  = 4;
	localparam int MB_TCONST  = 5;
	localparam int MB_TICK    = 14;
	localparam logic [15:0] MODE_SINGLE_SHOT = 16'h8001;

	// clock status codes
	localparam logic [7:0] STATUS_OK  = 8'd0;
	localparam logic [7:0] STATUS_BAD = 8'd4;

	// tick range is these numerators over the tick rate
	localparam int TICK_LO_NUM = 900000;
	localparam int TICK_HI_NUM = 1100000;

	// reset values
	localparam logic [9:0]  TOL_RST   = 10'd100;
	localparam logic [19:0] PREC_RST  = 20'd1;
	localparam logic [31:0] ERR_RST   = 32'h7000_0000;
	localparam logic [15:0] TICK_RST  = 16'd10000;

	// one adjust request
	typedef struct packed {
		logic [15:0]        mode;
		logic               privileged;
		logic signed [31:0] offset_in;
		logic signed [31:0] frequency_in;
		logic signed [31:0] maxerror_in;
		logic signed [31:0] esterror_in;
		logic [7:0]         status_in;
		logic [4:0]         tconst_in;
		logic [15:0]        tick_in;
		logic [31:0]        now_seconds;
	} req_t;

	// one readback result
	typedef struct packed {
		err_code_t          error_code;
		logic signed [31:0] adjust_out;
		logic signed [31:0] frequency_out;
		logic signed [31:0] maxerror_out;
		logic signed [31:0] esterror_out;
		logic [7:0]         status_out;
		logic [4:0]         tconst_out;
		logic [15:0]        tick_out;
		logic [19:0]        precision_out;
		logic [9:0]         tolerance_out;
	} rsp_t;

endpackage

@@ hdl/clock_discipline_adjust_top.sv @@
// Clock discipline adjust: takes one adjust request per transaction on the s_ side and
// returns one readback result per request on the m_ side, in order. A request enters an
// input register, then the checks, field writes and frequency steer (one 19x11 multiply,
// variable shift, add and clamp against the tolerance) run combinationally into the
// result register, so a request can be taken on every clock unless the output stalls; its
// result passes both registers. The clock state is updated at the same edge the result is
// loaded, so each request sees the state left by the one before. Results stall in the
// output register while m_tready is low; the input register keeps accepting until it
// too is full. m_tuser carries the error code; a failed request leaves the state unchanged
// and returns zero in every m_tdata field. tolerance and precision are set through the
// cfg port, which is always ready and should only be written while the block is idle.
module clock_discipline_adjust_top #(
	parameter int PHASE_SHIFT = 12,
	parameter int FREQ_SHIFT = 16,
	parameter int MAX_ELAPSED = 1024,
	parameter int TICK_RATE = 100
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cda_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cda_pkg::CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// offset_in, frequency_in, maxerror_in, esterror_in, status_in, tconst_in,
	// tick_in, now_seconds, zero pad
	input  logic [191:0] s_tdata,
	// mode, privileged
	input  logic [16:0]  s_tuser,
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// adjust_out, frequency_out, maxerror_out, esterror_out, status_out, tconst_out,
	// tick_out, precision_out, tolerance_out, zero pad
	output logic [191:0] m_tdata,
	// error_code
	output logic [1:0]   m_tuser
);
	import cda_pkg::*;

	logic [9:0]  tol_q;
	logic [19:0] prec_q;
	req_t        req_in;
	req_t        req_s1;
	logic        valid_s1;
	logic        advance;
	logic        commit;
	err_code_t   err;
	rsp_t        rsp;
	rsp_t        out_q;
	logic        out_valid_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RST;
			prec_q <= PREC_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TOLERANCE: tol_q <= cfg_data[9:0];
				REG_PRECISION: prec_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack request
	always_comb begin
		req_in.mode = s_tuser[15:0];
		req_in.privileged = s_tuser[16];
		req_in.offset_in = s_tdata[31:0];
		req_in.frequency_in = s_tdata[63:32];
		req_in.maxerror_in = s_tdata[95:64];
		req_in.esterror_in = s_tdata[127:96];
		req_in.status_in = s_tdata[135:128];
		req_in.tconst_in = s_tdata[140:136];
		req_in.tick_in = s_tdata[156:141];
		req_in.now_seconds = s_tdata[188:157];
	end

	// handshake
	assign advance = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign commit = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= req_in;
		end
	end

	cda_check #(
		.PHASE_SHIFT(PHASE_SHIFT),
		.TICK_RATE(TICK_RATE)
	) u_check (
		.req(req_s1),
		.err(err)
	);

	cda_update #(
		.PHASE_SHIFT(PHASE_SHIFT),
		.FREQ_SHIFT(FREQ_SHIFT),
		.MAX_ELAPSED(MAX_ELAPSED)
	) u_update (
		.clk(clk),
		.arst_n(arst_n),
		.commit(commit),
		.req(req_s1),
		.err(err),
		.tolerance(tol_q),
		.precision(prec_q),
		.rsp(rsp)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= rsp;
		end
	end

	// pack result
	assign m_tvalid = out_valid_q;
	assign m_tuser = out_q.error_code;
	assign m_tdata = {5'd0, out_q.tolerance_out, out_q.precision_out, out_q.tick_out,
		out_q.tconst_out, out_q.status_out, out_q.esterror_out, out_q.maxerror_out,
		out_q.frequency_out, out_q.adjust_out};

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ERR_NONE) |-> (m_tdata == '0))
		else $error("failed request carries nonzero readback");

	a_ready_only_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input blocked without output stall");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> m_tvalid)
		else $error("processed request did not reach the output");
`endif

endmodule

@@ hdl/cda_check.sv @@
module cda_check #(
	parameter int PHASE_SHIFT = 12,
	parameter int TICK_RATE = 100
) (
	input  cda_pkg::req_t    req,
	output cda_pkg::err_code_t err
);
	import cda_pkg::*;

	localparam logic signed [32:0] PHASE_LIM = 33'sd1 <<< (31 - PHASE_SHIFT);
	localparam logic [15:0] TICK_MIN = 16'(TICK_LO_NUM / TICK_RATE);
	localparam logic [15:0] TICK_MAX = 16'(TICK_HI_NUM / TICK_RATE);

	logic signed [32:0] off_x;
	logic off_bad;
	logic tick_bad;

	assign off_x = 33'(req.offset_in);
	assign off_bad = (off_x >= PHASE_LIM) || (off_x <= -PHASE_LIM);
	assign tick_bad = (req.tick_in < TICK_MIN) || (req.tick_in > TICK_MAX);

	// checks in priority order
	always_comb begin
		err = ERR_NONE;
		if (req.mode != '0 && !req.privileged) begin
			err = ERR_PERM;
		end else if (req.mode[MB_OFFSET] && off_bad) begin
			err = ERR_INVAL;
		end else if (req.mode[MB_STATUS] && req.status_in > STATUS_BAD) begin
			err = ERR_INVAL;
		end else if (req.mode[MB_TICK] && tick_bad) begin
			err = ERR_INVAL;
		end
	end

endmodule

@@ hdl/cda_update.sv @@
module cda_update #(
	parameter int PHASE_SHIFT = 12,
	parameter int FREQ_SHIFT = 16,
	parameter int MAX_ELAPSED = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               commit,
	input  cda_pkg::req_t      req,
	input  cda_pkg::err_code_t err,
	input  logic [9:0]         tolerance,
	input  logic [19:0]        precision,
	output cda_pkg::rsp_t      rsp
);
	import cda_pkg::*;

	localparam int FREQW = FREQ_SHIFT + 16;
	localparam int OFFW = 31 - PHASE_SHIFT;
	localparam int ELW = $clog2(MAX_ELAPSED + 3);
	localparam int MAGW = OFFW + ELW;
	localparam int SUMW = ((MAGW > FREQW) ? MAGW : FREQW) + 2;
	localparam logic [31:0] EL_MAX = 32'(MAX_ELAPSED + 2);

	logic [7:0]              status_q, status_n, status_base;
	logic signed [FREQW-1:0] freq_q, freq_n, freq_base, freq_steer;
	logic [31:0]             adjust_q, adjust_n;
	logic [31:0]             ref_sec_q, ref_sec_n;
	logic [31:0]             maxerr_q, maxerr_n;
	logic [31:0]             esterr_q, esterr_n;
	logic [4:0]              tconst_q, tconst_n;
	logic [15:0]             tick_q, tick_n;

	logic                    upd;
	logic                    single_shot;
	logic                    steer;
	logic [31:0]             elapsed;
	logic [ELW-1:0]          el;
	logic [31:0]             off_abs;
	logic [MAGW-1:0]         prod;
	logic [MAGW-1:0]         mag;
	logic [5:0]              shamt;
	logic signed [SUMW-1:0]  sum;
	logic signed [SUMW-1:0]  tol_lim;
	logic signed [FREQW:0]   freq_rnd;
	logic signed [FREQW:0]   freq_rd;

	assign upd = (req.mode != '0);
	assign single_shot = (req.mode == MODE_SINGLE_SHOT);
	assign steer = req.mode[MB_OFFSET] && !single_shot;

	// field writes selected by mode
	assign status_base = (upd && status_q == STATUS_BAD) ? STATUS_OK : status_q;
	assign status_n = req.mode[MB_STATUS] ? req.status_in : status_base;
	assign freq_base = req.mode[MB_FREQ] ?
		(FREQW'(req.frequency_in) <<< (FREQ_SHIFT - 16)) : freq_q;
	assign maxerr_n = req.mode[MB_MAXERR] ? req.maxerror_in : maxerr_q;
	assign esterr_n = req.mode[MB_ESTERR] ? req.esterror_in : esterr_q;
	assign tconst_n = req.mode[MB_TCONST] ? req.tconst_in : tconst_q;
	assign tick_n = req.mode[MB_TICK] ? req.tick_in : tick_q;
	assign adjust_n = single_shot ? req.offset_in : adjust_q;
	assign ref_sec_n = steer ? req.now_seconds : ref_sec_q;

	// elapsed seconds, zero when negative or too large
	assign elapsed = req.now_seconds - ref_sec_q;
	assign el = (!elapsed[31] && elapsed <= EL_MAX) ? elapsed[ELW-1:0] : '0;

	// frequency steer: |offset| * elapsed >> 2*tconst, sign of offset
	assign off_abs = req.offset_in[31] ? (32'd0 - req.offset_in) : req.offset_in;
	assign prod = MAGW'(off_abs[OFFW-1:0]) * MAGW'(el);
	assign shamt = {tconst_n, 1'b0};
	assign mag = prod >> shamt;
	assign sum = req.offset_in[31] ?
		(SUMW'(freq_base) - $signed(SUMW'(mag))) :
		(SUMW'(freq_base) + $signed(SUMW'(mag)));
	assign tol_lim = $signed(SUMW'(tolerance)) <<< FREQ_SHIFT;

	// clamp to the tolerance
	always_comb begin
		if (sum > tol_lim) begin
			freq_steer = FREQW'(tol_lim);
		end else if (sum < -tol_lim) begin
			freq_steer = FREQW'(-tol_lim);
		end else begin
			freq_steer = FREQW'(sum);
		end
	end

	assign freq_n = steer ? freq_steer : freq_base;

	// readback rounding
	assign freq_rnd = (FREQW+1)'(freq_n) + (FREQW+1)'(1);
	assign freq_rd = freq_rnd >>> (FREQ_SHIFT - 16);

	// clock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= STATUS_BAD;
			freq_q <= '0;
			adjust_q <= '0;
			ref_sec_q <= '0;
			maxerr_q <= ERR_RST;
			esterr_q <= ERR_RST;
			tconst_q <= '0;
			tick_q <= TICK_RST;
		end else if (commit && err == ERR_NONE && upd) begin
			status_q <= status_n;
			freq_q <= freq_n;
			adjust_q <= adjust_n;
			ref_sec_q <= ref_sec_n;
			maxerr_q <= maxerr_n;
			esterr_q <= esterr_n;
			tconst_q <= tconst_n;
			tick_q <= tick_n;
		end
	end

	// result: state after this request, adjust_out from before it, all zero on error
	always_comb begin
		rsp = '0;
		rsp.error_code = err;
		if (err == ERR_NONE) begin
			rsp.adjust_out = adjust_q;
			rsp.frequency_out = freq_rd[31:0];
			rsp.maxerror_out = maxerr_n;
			rsp.esterror_out = esterr_n;
			rsp.status_out = status_n;
			rsp.tconst_out = tconst_n;
			rsp.tick_out = tick_n;
			rsp.precision_out = precision;
			rsp.tolerance_out = tolerance;
		end
	end

endmodule
